// ----- design/pmed_pkg.sv -----
package pmed_pkg;

  localparam logic [17:0] FAR_DIST  = 18'd200000;
  localparam int          ErrLimit  = 20;
  localparam logic [7:0]  CELL_MASK = 8'd248;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_PIXEL = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_DITHER  = 2'd0,
    CFG_WIDTH   = 2'd1,
    CFG_HEIGHT  = 2'd2,
    CFG_PALETTE = 2'd3
  } cfg_index_e;

  typedef enum logic [3:0] {
    EOP_NONE,
    EOP_RD_CUR,
    EOP_RD_CUR_AHEAD,
    EOP_WR_CUR_AHEAD7,
    EOP_WR_NXT_AHEAD_E,
    EOP_RD_NXT,
    EOP_WR_NXT5,
    EOP_RD_NXT_BEHIND,
    EOP_WR_NXT_BEHIND3
  } err_op_e;

  typedef struct packed {
    logic    sweep_start;
    logic    sweep_run;
    logic    pal_load;
    logic    pix_latch;
    logic    px_correct;
    logic    cache_wr;
    logic    idx_load_cache;
    logic    srch_start;
    logic    srch_run;
    logic    idx_load_search;
    logic    pal_rd_chosen;
    logic    err_calc;
    logic    out_load;
    logic    cnt_advance;
    err_op_e err_op;
  } pmed_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic img_done;
    logic dither_on;
    logic cache_hit;
    logic srch_done;
    logic out_busy;
  } pmed_status_t;

endpackage

// ----- design/palette_map_error_diffusion_core.sv -----
// Palette mapper with serpentine error diffusion.
// Input channel (in_valid_i/in_ready_o): one request per transfer; req_type_i
// selects start of image, palette entry load, or pixel. Only pixels inside
// the configured image give a result; other requests give none.
// Output channel (out_valid_o/out_ready_i): color index, column and row end
// for each mapped pixel, held in an output register until transferred.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 dither enable, 1 width, 2 height, 3 palette size).
// A pixel search reads one palette entry per cycle through the single palette
// port; when dithering, serialized error row and cache accesses are added,
// and a cache hit skips the search. One item at a time.
// After reset and after each start request a clearing pass sweeps the cache
// and error rows; no input is taken meanwhile.
// When the receiver stalls, a finished result waits in the output register
// and the next pixel is taken and processed up to its own result.
module palette_map_error_diffusion_core
  import pmed_pkg::*;
#(
  parameter int MAX_WIDTH     = 2048,
  parameter int PALETTE_DEPTH = 256,
  parameter int CACHE_ENTRIES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  color_index_o,
  output logic [10:0] column_o,
  output logic        row_end_o
);

  pmed_cmd_t    cmd;
  pmed_status_t status;

  pmed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pmed_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .color_index_o (color_index_o),
    .column_o      (column_o),
    .row_end_o     (row_end_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

// ----- design/pmed_ctrl.sv -----
module pmed_ctrl
  import pmed_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [1:0]   req_type_i,
  output logic         in_ready_o,
  input  pmed_status_t status_i,
  output pmed_cmd_t    cmd_o
);

  typedef enum logic [17:0] {
    S_CLEAR     = 18'h00001,
    S_IDLE      = 18'h00002,
    S_CUR_RD    = 18'h00004,
    S_CORR      = 18'h00008,
    S_KEY_RD    = 18'h00010,
    S_KEY_CHK   = 18'h00020,
    S_SRCH_INIT = 18'h00040,
    S_SEARCH    = 18'h00080,
    S_CACHE_WR  = 18'h00100,
    S_PAL_RD    = 18'h00200,
    S_ERRC      = 18'h00400,
    S_A7        = 18'h00800,
    S_WE        = 18'h01000,
    S_RD5       = 18'h02000,
    S_WR5       = 18'h04000,
    S_RD3       = 18'h08000,
    S_WR3       = 18'h10000,
    S_DONE      = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.err_op = EOP_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_run = 1'b1;
        if (status_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_START: begin
              cmd_o.sweep_start = 1'b1;
              state_d = S_CLEAR;
            end
            REQ_LOAD: cmd_o.pal_load = 1'b1;
            REQ_PIXEL: begin
              if (!status_i.img_done) begin
                cmd_o.pix_latch = 1'b1;
                state_d = status_i.dither_on ? S_CUR_RD : S_SRCH_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_CUR_RD: begin
        cmd_o.err_op = EOP_RD_CUR;
        state_d = S_CORR;
      end
      S_CORR: begin
        cmd_o.px_correct = 1'b1;
        state_d = S_KEY_RD;
      end
      S_KEY_RD: state_d = S_KEY_CHK;
      S_KEY_CHK: begin
        if (status_i.cache_hit) begin
          cmd_o.idx_load_cache = 1'b1;
          state_d = S_PAL_RD;
        end else begin
          state_d = S_SRCH_INIT;
        end
      end
      S_SRCH_INIT: begin
        cmd_o.srch_start = 1'b1;
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.srch_run = 1'b1;
        if (status_i.srch_done) begin
          cmd_o.idx_load_search = 1'b1;
          state_d = status_i.dither_on ? S_CACHE_WR : S_DONE;
        end
      end
      S_CACHE_WR: begin
        cmd_o.cache_wr = 1'b1;
        state_d = S_PAL_RD;
      end
      S_PAL_RD: begin
        cmd_o.pal_rd_chosen = 1'b1;
        state_d = S_ERRC;
      end
      S_ERRC: begin
        cmd_o.err_calc = 1'b1;
        cmd_o.err_op = EOP_RD_CUR_AHEAD;
        state_d = S_A7;
      end
      S_A7: begin
        cmd_o.err_op = EOP_WR_CUR_AHEAD7;
        state_d = S_WE;
      end
      S_WE: begin
        cmd_o.err_op = EOP_WR_NXT_AHEAD_E;
        state_d = S_RD5;
      end
      S_RD5: begin
        cmd_o.err_op = EOP_RD_NXT;
        state_d = S_WR5;
      end
      S_WR5: begin
        cmd_o.err_op = EOP_WR_NXT5;
        state_d = S_RD3;
      end
      S_RD3: begin
        cmd_o.err_op = EOP_RD_NXT_BEHIND;
        state_d = S_WR3;
      end
      S_WR3: begin
        cmd_o.err_op = EOP_WR_NXT_BEHIND3;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.cnt_advance = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/pmed_datapath.sv -----
module pmed_datapath
  import pmed_pkg::*;
#(
  parameter int MAX_WIDTH     = 2048,
  parameter int PALETTE_DEPTH = 256,
  parameter int CACHE_ENTRIES = 32768
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic [7:0]   entry_index_i,
  input  logic [7:0]   red_i,
  input  logic [7:0]   green_i,
  input  logic [7:0]   blue_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [7:0]   color_index_o,
  output logic [10:0]  column_o,
  output logic         row_end_o,
  input  pmed_cmd_t    cmd_i,
  output pmed_status_t status_o
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WW       = CW + 1;
  localparam int PW       = $clog2(PALETTE_DEPTH);
  localparam int KW       = $clog2(CACHE_ENTRIES);
  localparam int RowSpan  = MAX_WIDTH + 2;
  localparam int ErrDepth = 2 * RowSpan;
  localparam int EAW      = $clog2(ErrDepth);

  // configuration
  logic        cfg_dither_q;
  logic [11:0] cfg_width_q;
  logic [15:0] cfg_height_q;
  logic [8:0]  cfg_palette_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dither_q  <= 1'b1;
      cfg_width_q   <= 12'd640;
      cfg_height_q  <= 16'd480;
      cfg_palette_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DITHER:  cfg_dither_q  <= cfg_data_i[0];
        CFG_WIDTH:   cfg_width_q   <= cfg_data_i[11:0];
        CFG_HEIGHT:  cfg_height_q  <= cfg_data_i[15:0];
        CFG_PALETTE: cfg_palette_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // position counters
  logic [CW-1:0] col_cnt_q;
  logic [15:0]   row_cnt_q;
  logic          odd_q;
  logic [WW-1:0] w_eff, wm1;
  logic [CW-1:0] pos, col;
  logic [WW-1:0] col_w;
  logic [CW-1:0] pos_q, col_q;
  logic          row_end_q;
  logic          img_done;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    wm1 = w_eff - WW'(1);
    if ({1'b0, col_cnt_q} >= wm1) pos = wm1[CW-1:0];
    else pos = col_cnt_q;
    col_w = wm1 - {1'b0, pos};
    col = odd_q ? col_w[CW-1:0] : pos;
  end

  assign img_done = (row_cnt_q >= cfg_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      odd_q     <= 1'b0;
    end else if (cmd_i.sweep_start) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      odd_q     <= 1'b0;
    end else if (cmd_i.cnt_advance) begin
      if (row_end_q) begin
        col_cnt_q <= '0;
        row_cnt_q <= row_cnt_q + 16'd1;
        odd_q     <= ~odd_q;
      end else begin
        col_cnt_q <= pos_q + CW'(1);
      end
    end
  end

  // pixel register
  logic [2:0][7:0] px_q, px_corr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_latch) begin
      px_q      <= {red_i, green_i, blue_i};
      pos_q     <= pos;
      col_q     <= col;
      row_end_q <= ({1'b0, pos} == wm1);
    end else if (cmd_i.px_correct) begin
      px_q <= px_corr;
    end
  end

  // clearing sweep
  logic [KW-1:0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_start) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_run) begin
      sweep_q <= sweep_q + KW'(1);
    end
  end

  // palette memory
  logic [23:0]   pal_mem [PALETTE_DEPTH];
  logic [23:0]   pal_rdata_q;
  logic [PW:0]   n_eff, rd_idx_q;
  logic [PW-1:0] pal_addr, idx_q, best_q, cmp_idx_q;
  logic          cmp_valid_q;
  logic [17:0]   mind_q, dist_sum;
  logic          pal_we;

  assign pal_we   = cmd_i.pal_load && (32'(entry_index_i) < PALETTE_DEPTH);
  assign pal_addr = pal_we ? PW'(entry_index_i) :
                    cmd_i.pal_rd_chosen ? idx_q : rd_idx_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (pal_we) pal_mem[pal_addr] <= {red_i, green_i, blue_i};
    pal_rdata_q <= pal_mem[pal_addr];
  end

  // nearest search
  logic signed [8:0]  dch [3];
  logic signed [17:0] sq  [3];

  always_comb begin
    if (32'(cfg_palette_q) > PALETTE_DEPTH) n_eff = (PW+1)'(PALETTE_DEPTH);
    else n_eff = (PW+1)'(cfg_palette_q);
    for (int k = 0; k < 3; k++) begin
      dch[k] = $signed({1'b0, pal_rdata_q[23-8*k -: 8]}) - $signed({1'b0, px_q[2-k]});
      sq[k]  = dch[k] * dch[k];
    end
    dist_sum = 18'($unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_valid_q <= 1'b0;
    end else if (cmd_i.srch_start) begin
      cmp_valid_q <= 1'b0;
    end else if (cmd_i.srch_run) begin
      cmp_valid_q <= (rd_idx_q < n_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_start) begin
      rd_idx_q <= '0;
      mind_q   <= FAR_DIST;
      best_q   <= '0;
    end else if (cmd_i.srch_run) begin
      if (rd_idx_q < n_eff) begin
        rd_idx_q  <= rd_idx_q + (PW+1)'(1);
        cmp_idx_q <= rd_idx_q[PW-1:0];
      end
      if (cmp_valid_q && (dist_sum < mind_q)) begin
        mind_q <= dist_sum;
        best_q <= cmp_idx_q;
      end
    end
  end

  // color cache
  logic [8:0]    cache_mem [CACHE_ENTRIES];
  logic [8:0]    cache_rdata_q;
  logic [KW-1:0] cache_addr;
  logic [14:0]   key;

  assign key = {px_q[2][7:3], px_q[1][7:3], px_q[0][7:3]};
  assign cache_addr = cmd_i.sweep_run ? sweep_q : KW'(key);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_run) cache_mem[cache_addr] <= '0;
    else if (cmd_i.cache_wr) cache_mem[cache_addr] <= {1'b1, 8'(idx_q)};
    cache_rdata_q <= cache_mem[cache_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load_cache) idx_q <= PW'(cache_rdata_q[7:0]);
    else if (cmd_i.idx_load_search) idx_q <= best_q;
  end

  // error rows
  logic [47:0]        err_mem [ErrDepth];
  logic [47:0]        err_rdata_q, err_wdata;
  logic [EAW-1:0]     err_addr;
  logic               err_we, row_sel;
  logic [WW-1:0]      sidx;
  logic signed [15:0] err_ch [3];
  logic signed [16:0] csum   [3];
  logic signed [12:0] corr   [3];
  logic signed [13:0] vsum   [3];
  logic signed [9:0]  ediff  [3];
  logic signed [5:0]  e_d    [3];
  logic signed [5:0]  e_q    [3];
  logic signed [15:0] e16    [3];
  logic [15:0]        base5  [3];

  always_comb begin
    row_sel = odd_q;
    sidx    = {1'b0, col_q} + WW'(1);
    err_we  = 1'b0;
    case (cmd_i.err_op)
      EOP_RD_CUR: begin
        row_sel = odd_q;
        sidx    = {1'b0, col_q} + WW'(1);
      end
      EOP_RD_CUR_AHEAD, EOP_WR_CUR_AHEAD7: begin
        row_sel = odd_q;
        sidx    = odd_q ? {1'b0, col_q} : {1'b0, col_q} + WW'(2);
        err_we  = (cmd_i.err_op == EOP_WR_CUR_AHEAD7);
      end
      EOP_WR_NXT_AHEAD_E: begin
        row_sel = ~odd_q;
        sidx    = odd_q ? {1'b0, col_q} : {1'b0, col_q} + WW'(2);
        err_we  = 1'b1;
      end
      EOP_RD_NXT, EOP_WR_NXT5: begin
        row_sel = ~odd_q;
        sidx    = {1'b0, col_q} + WW'(1);
        err_we  = (cmd_i.err_op == EOP_WR_NXT5);
      end
      EOP_RD_NXT_BEHIND, EOP_WR_NXT_BEHIND3: begin
        row_sel = ~odd_q;
        sidx    = odd_q ? {1'b0, col_q} + WW'(2) : {1'b0, col_q};
        err_we  = (cmd_i.err_op == EOP_WR_NXT_BEHIND3);
      end
      default: ;
    endcase
    if (cmd_i.sweep_run) begin
      err_addr = sweep_q[EAW-1:0];
      err_we   = (32'(sweep_q) < ErrDepth);
    end else begin
      err_addr = (row_sel ? EAW'(RowSpan) : EAW'(0)) + EAW'(sidx);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      err_ch[k] = $signed(err_rdata_q[47-16*k -: 16]);
      csum[k]   = 17'(err_ch[k]) + 17'sd8;
      corr[k]   = 13'(csum[k] >>> 4);
      vsum[k]   = 14'(corr[k]) + $signed({6'b0, px_q[2-k]});
      if (vsum[k] < 0) px_corr[2-k] = 8'd0;
      else if (vsum[k] > 14'sd255) px_corr[2-k] = 8'd255;
      else px_corr[2-k] = vsum[k][7:0];

      ediff[k] = $signed({2'b0, px_q[2-k]}) - $signed({2'b0, pal_rdata_q[23-8*k -: 8]});
      if (ediff[k] > 10'(ErrLimit)) e_d[k] = 6'(ErrLimit);
      else if (ediff[k] < -10'(ErrLimit)) e_d[k] = -6'(ErrLimit);
      else e_d[k] = ediff[k][5:0];

      e16[k]   = 16'(e_q[k]);
      base5[k] = (pos_q == '0) ? 16'd0 : err_rdata_q[47-16*k -: 16];
      case (cmd_i.err_op)
        EOP_WR_CUR_AHEAD7:
          err_wdata[47-16*k -: 16] = err_rdata_q[47-16*k -: 16] + 16'(e16[k] * 16'sd7);
        EOP_WR_NXT5:
          err_wdata[47-16*k -: 16] = base5[k] + 16'(e16[k] * 16'sd5);
        EOP_WR_NXT_BEHIND3:
          err_wdata[47-16*k -: 16] = err_rdata_q[47-16*k -: 16] + 16'(e16[k] * 16'sd3);
        EOP_WR_NXT_AHEAD_E:
          err_wdata[47-16*k -: 16] = e16[k];
        default:
          err_wdata[47-16*k -: 16] = 16'd0;
      endcase
    end
    if (cmd_i.sweep_run) err_wdata = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_calc) begin
      for (int k = 0; k < 3; k++) e_q[k] <= e_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_we) err_mem[err_addr] <= err_wdata;
    err_rdata_q <= err_mem[err_addr];
  end

  // result register
  logic        out_valid_q;
  logic [7:0]  color_q;
  logic [10:0] column_q;
  logic        row_end_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      color_q       <= 8'(idx_q);
      column_q      <= 11'(col_q);
      row_end_out_q <= row_end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_q;
  assign column_o      = column_q;
  assign row_end_o     = row_end_out_q;

  assign status_o.sweep_last = (sweep_q == KW'(CACHE_ENTRIES - 1));
  assign status_o.img_done   = img_done;
  assign status_o.dither_on  = cfg_dither_q;
  assign status_o.cache_hit  = cache_rdata_q[8];
  assign status_o.srch_done  = (rd_idx_q >= n_eff) && !cmp_valid_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_valid_q |-> ((PW+1)'(cmp_idx_q) < n_eff))
    else $error("search compared entry beyond palette size");

  a_latch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pix_latch |-> !img_done)
    else $error("pixel started after image complete");
`endif

endmodule
